/* hdl/brl_pkg.sv */
// Shared constants for the line rasterizer: command codes, slope class codes
// and default widths. No dependencies.
package brl_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int COLOR_BITS         = 32;

   typedef logic [1:0] octant_type;

   // slope classes
   localparam octant_type CLS_STEEP_UP   = 2'd0; // major y, x steps up
   localparam octant_type CLS_STEEP_DOWN = 2'd1; // major y, x steps down
   localparam octant_type CLS_FLAT_UP    = 2'd2; // major x, y steps up
   localparam octant_type CLS_FLAT_DOWN  = 2'd3; // major x, y steps down

   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   function automatic logic is_steep(input octant_type cls);
      return (cls == CLS_STEEP_UP) || (cls == CLS_STEEP_DOWN);
   endfunction

   function automatic logic is_up(input octant_type cls);
      return (cls == CLS_STEEP_UP) || (cls == CLS_FLAT_UP);
   endfunction

endpackage

/* hdl/brl_setup.sv */
// Line setup: classifies the slope, orders the endpoints and derives the
// first pixel plus decision and increment terms. Depends on brl_pkg.
module brl_setup #(
   parameter int COORD_BITS = brl_pkg::COORD_BITS_DEFAULT
) (
   input  logic [COORD_BITS-1:0]   start_x,
   input  logic [COORD_BITS-1:0]   start_y,
   input  logic [COORD_BITS-1:0]   end_x,
   input  logic [COORD_BITS-1:0]   end_y,
   output brl_pkg::octant_type     cls,
   output logic [COORD_BITS-1:0]   first_x,
   output logic [COORD_BITS-1:0]   first_y,
   output logic [COORD_BITS-1:0]   major_end,
   output logic signed [COORD_BITS+2:0] decision,
   output logic signed [COORD_BITS+2:0] inc_no_step,
   output logic signed [COORD_BITS+2:0] inc_step,
   output logic                    last
);
   import brl_pkg::*;

   localparam int DD = COORD_BITS + 1;
   localparam int DW = COORD_BITS + 3;

   logic signed [DD-1:0] dx, dy, ndx, ndy, sdx, sdy;
   logic signed [DW-1:0] wmin, wmaj;
   logic                 swap, steep;
   logic [COORD_BITS-1:0] major_start;

   assign dx  = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
   assign dy  = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
   assign ndx = -dx;
   assign ndy = -dy;

   always_comb begin
      if (dx == '0) begin
         cls = CLS_STEEP_UP;
      end else if (!dx[DD-1]) begin
         if (dy >= dx)          cls = CLS_STEEP_UP;
         else if (dy <= ndx)    cls = CLS_STEEP_DOWN;
         else if (!dy[DD-1])    cls = CLS_FLAT_UP;
         else                   cls = CLS_FLAT_DOWN;
      end else begin
         if (dy <= dx)          cls = CLS_STEEP_UP;
         else if (dy >= ndx)    cls = CLS_STEEP_DOWN;
         else if (dy[DD-1] || (dy == '0)) cls = CLS_FLAT_UP;
         else                   cls = CLS_FLAT_DOWN;
      end
   end

   assign steep = is_steep(cls);
   // order endpoints so the major axis rises
   assign swap  = steep ? (start_y > end_y) : (start_x > end_x);
   assign sdx   = swap ? ndx : dx;
   assign sdy   = swap ? ndy : dy;

   assign wmin = steep ? {{2{sdx[DD-1]}}, sdx} : {{2{sdy[DD-1]}}, sdy};
   assign wmaj = steep ? {{2{sdy[DD-1]}}, sdy} : {{2{sdx[DD-1]}}, sdx};

   always_comb begin
      inc_no_step = wmin + wmin;
      if (is_up(cls)) begin
         inc_step = (wmin - wmaj) + (wmin - wmaj);
         decision = wmin + wmin - wmaj;
      end else begin
         inc_step = (wmin + wmaj) + (wmin + wmaj);
         decision = wmin + wmin + wmaj;
      end
   end

   assign first_x     = swap ? end_x : start_x;
   assign first_y     = swap ? end_y : start_y;
   assign major_end   = steep ? (swap ? start_y : end_y) : (swap ? start_x : end_x);
   assign major_start = steep ? first_y : first_x;
   assign last        = (major_start >= major_end);

endmodule

/* hdl/brl_step.sv */
// Per-pixel advance: steps the major axis, decides the minor step from the
// decision term and flags the end point. Depends on brl_pkg.
module brl_step #(
   parameter int COORD_BITS = brl_pkg::COORD_BITS_DEFAULT
) (
   input  brl_pkg::octant_type           cls,
   input  logic [COORD_BITS-1:0]         cur_x,
   input  logic [COORD_BITS-1:0]         cur_y,
   input  logic [COORD_BITS-1:0]         major_end,
   input  logic signed [COORD_BITS+2:0]  decision,
   input  logic signed [COORD_BITS+2:0]  inc_no_step,
   input  logic signed [COORD_BITS+2:0]  inc_step,
   output logic [COORD_BITS-1:0]         next_x,
   output logic [COORD_BITS-1:0]         next_y,
   output logic signed [COORD_BITS+2:0]  next_decision,
   output logic                          last
);
   import brl_pkg::*;

   localparam int DW = COORD_BITS + 3;

   logic take, up, steep;
   logic [COORD_BITS-1:0] minor_cur, minor_next, major_next;

   assign up    = is_up(cls);
   assign steep = is_steep(cls);
   // up classes step on a positive term, down classes on a negative one
   assign take  = up ? (!decision[DW-1] && (decision != '0)) : decision[DW-1];

   assign minor_cur  = steep ? cur_x : cur_y;
   assign major_next = (steep ? cur_y : cur_x) + COORD_BITS'(1);
   assign minor_next = !take ? minor_cur :
                       up    ? minor_cur + COORD_BITS'(1) : minor_cur - COORD_BITS'(1);

   assign next_x        = steep ? minor_next : major_next;
   assign next_y        = steep ? major_next : minor_next;
   assign next_decision = decision + (take ? inc_step : inc_no_step);
   assign last          = (major_next >= major_end);

endmodule

/* hdl/bresenham_line_rasterizer_top.sv */
// Bresenham line rasterizer top level: line state registers and result
// register. Depends on brl_pkg, brl_setup and brl_step.
//
// A start transaction (cmd = start) loads two endpoints and a color and
// returns the first pixel; each advance transaction returns the next pixel
// of the line, with last_pixel set on the end point, after which the block
// is idle. An advance while idle returns a result with pixel_valid low and
// all other fields zero; a start while a line is in progress drops that
// line. One transaction is accepted per clock while req_stall is low; its
// result appears in the result register on the next cycle, so a steady
// stream of advances yields one pixel per clock. The per-pixel loop is a
// single add on the decision register, a major-axis increment and a
// minor-axis step. The result register decouples the two sides: req_stall
// is raised only while a result waits and rsp_stall is high.
module bresenham_line_rasterizer_top #(
   parameter int COORD_BITS = brl_pkg::COORD_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_cmd,
   input  logic [COORD_BITS-1:0]           req_start_x,
   input  logic [COORD_BITS-1:0]           req_start_y,
   input  logic [COORD_BITS-1:0]           req_end_x,
   input  logic [COORD_BITS-1:0]           req_end_y,
   input  logic [brl_pkg::COLOR_BITS-1:0]  req_line_color,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_pixel_valid,
   output logic [COORD_BITS-1:0]           rsp_pixel_x,
   output logic [COORD_BITS-1:0]           rsp_pixel_y,
   output logic [brl_pkg::COLOR_BITS-1:0]  rsp_pixel_color,
   output logic                            rsp_last_pixel
);
   import brl_pkg::*;

   localparam int DW = COORD_BITS + 3;

   // line state
   logic                   busy_ff, busy_in;
   logic [COORD_BITS-1:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]  major_end_ff, major_end_in;
   logic signed [DW-1:0]   decision_ff, decision_in;
   logic signed [DW-1:0]   inc_no_step_ff, inc_no_step_in;
   logic signed [DW-1:0]   inc_step_ff, inc_step_in;
   octant_type             cls_ff, cls_in;
   logic [COLOR_BITS-1:0]  color_ff, color_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   pix_valid_ff, pix_valid_in;
   logic [COORD_BITS-1:0]  pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   logic [COLOR_BITS-1:0]  pix_color_ff, pix_color_in;
   logic                   pix_last_ff, pix_last_in;

   logic accept;

   octant_type             su_cls;
   logic [COORD_BITS-1:0]  su_x, su_y, su_major_end;
   logic signed [DW-1:0]   su_decision, su_inc_no_step, su_inc_step;
   logic                   su_last;

   logic [COORD_BITS-1:0]  st_x, st_y;
   logic signed [DW-1:0]   st_decision;
   logic                   st_last;

   brl_setup #(.COORD_BITS(COORD_BITS)) u_setup (
      .start_x     (req_start_x),
      .start_y     (req_start_y),
      .end_x       (req_end_x),
      .end_y       (req_end_y),
      .cls         (su_cls),
      .first_x     (su_x),
      .first_y     (su_y),
      .major_end   (su_major_end),
      .decision    (su_decision),
      .inc_no_step (su_inc_no_step),
      .inc_step    (su_inc_step),
      .last        (su_last)
   );

   brl_step #(.COORD_BITS(COORD_BITS)) u_step (
      .cls           (cls_ff),
      .cur_x         (cur_x_ff),
      .cur_y         (cur_y_ff),
      .major_end     (major_end_ff),
      .decision      (decision_ff),
      .inc_no_step   (inc_no_step_ff),
      .inc_step      (inc_step_ff),
      .next_x        (st_x),
      .next_y        (st_y),
      .next_decision (st_decision),
      .last          (st_last)
   );

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      busy_in        = busy_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      major_end_in   = major_end_ff;
      decision_in    = decision_ff;
      inc_no_step_in = inc_no_step_ff;
      inc_step_in    = inc_step_ff;
      cls_in         = cls_ff;
      color_in       = color_ff;

      pix_valid_in   = pix_valid_ff;
      pix_x_in       = pix_x_ff;
      pix_y_in       = pix_y_ff;
      pix_color_in   = pix_color_ff;
      pix_last_in    = pix_last_ff;

      // drop the result once taken, hold it while stalled
      rsp_valid_in   = rsp_valid_ff & rsp_stall;

      if (accept) begin
         rsp_valid_in = 1'b1;
         if (req_cmd == CMD_START) begin
            cur_x_in       = su_x;
            cur_y_in       = su_y;
            major_end_in   = su_major_end;
            decision_in    = su_decision;
            inc_no_step_in = su_inc_no_step;
            inc_step_in    = su_inc_step;
            cls_in         = su_cls;
            color_in       = req_line_color;
            busy_in        = ~su_last;
            pix_valid_in   = 1'b1;
            pix_x_in       = su_x;
            pix_y_in       = su_y;
            pix_color_in   = req_line_color;
            pix_last_in    = su_last;
         end else if (busy_ff) begin
            cur_x_in       = st_x;
            cur_y_in       = st_y;
            decision_in    = st_decision;
            busy_in        = ~st_last;
            pix_valid_in   = 1'b1;
            pix_x_in       = st_x;
            pix_y_in       = st_y;
            pix_color_in   = color_ff;
            pix_last_in    = st_last;
         end else begin
            pix_valid_in   = 1'b0;
            pix_x_in       = '0;
            pix_y_in       = '0;
            pix_color_in   = '0;
            pix_last_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         major_end_ff   <= '0;
         decision_ff    <= '0;
         inc_no_step_ff <= '0;
         inc_step_ff    <= '0;
         cls_ff         <= CLS_STEEP_UP;
         color_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         major_end_ff   <= major_end_in;
         decision_ff    <= decision_in;
         inc_no_step_ff <= inc_no_step_in;
         inc_step_ff    <= inc_step_in;
         cls_ff         <= cls_in;
         color_ff       <= color_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_valid_ff <= pix_valid_in;
      pix_x_ff     <= pix_x_in;
      pix_y_ff     <= pix_y_in;
      pix_color_ff <= pix_color_in;
      pix_last_ff  <= pix_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_valid = pix_valid_ff;
   assign rsp_pixel_x     = pix_x_ff;
   assign rsp_pixel_y     = pix_y_ff;
   assign rsp_pixel_color = pix_color_ff;
   assign rsp_last_pixel  = pix_last_ff;

endmodule

/* tb/brl_checker.sv */
`timescale 1ns / 100ps
// Pixel checker for the line rasterizer: watches both channels, predicts each pixel
// from accepted transactions and compares it with the result channel. Depends on brl_pkg.
module brl_checker #(
   parameter int COORD_BITS = brl_pkg::COORD_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_cmd,
   input  logic [COORD_BITS-1:0]           req_start_x,
   input  logic [COORD_BITS-1:0]           req_start_y,
   input  logic [COORD_BITS-1:0]           req_end_x,
   input  logic [COORD_BITS-1:0]           req_end_y,
   input  logic [brl_pkg::COLOR_BITS-1:0]  req_line_color,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_pixel_valid,
   input  logic [COORD_BITS-1:0]           rsp_pixel_x,
   input  logic [COORD_BITS-1:0]           rsp_pixel_y,
   input  logic [brl_pkg::COLOR_BITS-1:0]  rsp_pixel_color,
   input  logic                            rsp_last_pixel,
   output int                              fail_count,
   output int                              pending_count,
   output int                              checked_count
);
   import brl_pkg::*;

   localparam int PW = COORD_BITS + 4;

   typedef struct packed {
      logic                  valid;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
   } pixel_type;

   pixel_type expected_pixels[$];

   // line state of the predictor
   logic                         line_busy;
   logic [COORD_BITS-1:0]        px;
   logic [COORD_BITS-1:0]        py;
   logic [COORD_BITS-1:0]        major_stop;
   logic signed [COORD_BITS+3:0] p_term;
   logic signed [COORD_BITS+3:0] inc_straight;
   logic signed [COORD_BITS+3:0] inc_diag;
   octant_type                   cls;
   logic [COLOR_BITS-1:0]        color_q;

   task automatic rasterize_step(
      input  logic                  cmd,
      input  logic [COORD_BITS-1:0] sx_in,
      input  logic [COORD_BITS-1:0] sy_in,
      input  logic [COORD_BITS-1:0] ex_in,
      input  logic [COORD_BITS-1:0] ey_in,
      input  logic [COLOR_BITS-1:0] color_in,
      output pixel_type             pix
   );
      int   sx, sy, ex, ey, dx, dy, t;
      logic steep, up, take, done;
      pix = '0;
      if (cmd == CMD_ADVANCE && !line_busy) begin
         pix = '0;
      end else begin
         if (cmd == CMD_START) begin
            sx = int'(sx_in);
            sy = int'(sy_in);
            ex = int'(ex_in);
            ey = int'(ey_in);
            dx = ex - sx;
            dy = ey - sy;
            if (dx == 0)
               cls = CLS_STEEP_UP;
            else if (dx > 0)
               cls = (dy >= dx) ? CLS_STEEP_UP : (dy <= -dx) ? CLS_STEEP_DOWN :
                     (dy >= 0) ? CLS_FLAT_UP : CLS_FLAT_DOWN;
            else
               cls = (dy <= dx) ? CLS_STEEP_UP : (dy >= -dx) ? CLS_STEEP_DOWN :
                     (dy <= 0) ? CLS_FLAT_UP : CLS_FLAT_DOWN;
            steep = (cls == CLS_STEEP_UP) || (cls == CLS_STEEP_DOWN);
            // order endpoints so the major axis rises
            if ((steep && sy > ey) || (!steep && sx > ex)) begin
               t = sx; sx = ex; ex = t;
               t = sy; sy = ey; ey = t;
               dx = -dx;
               dy = -dy;
            end
            case (cls)
               CLS_STEEP_UP: begin
                  inc_straight = PW'(2 * dx);
                  inc_diag     = PW'(2 * (dx - dy));
                  p_term       = PW'(2 * dx - dy);
                  major_stop   = ey[COORD_BITS-1:0];
               end
               CLS_STEEP_DOWN: begin
                  inc_straight = PW'(2 * dx);
                  inc_diag     = PW'(2 * (dx + dy));
                  p_term       = PW'(2 * dx + dy);
                  major_stop   = ey[COORD_BITS-1:0];
               end
               CLS_FLAT_UP: begin
                  inc_straight = PW'(2 * dy);
                  inc_diag     = PW'(2 * (dy - dx));
                  p_term       = PW'(2 * dy - dx);
                  major_stop   = ex[COORD_BITS-1:0];
               end
               default: begin
                  inc_straight = PW'(2 * dy);
                  inc_diag     = PW'(2 * (dy + dx));
                  p_term       = PW'(2 * dy + dx);
                  major_stop   = ex[COORD_BITS-1:0];
               end
            endcase
            px      = sx[COORD_BITS-1:0];
            py      = sy[COORD_BITS-1:0];
            color_q = color_in;
         end else begin
            steep = (cls == CLS_STEEP_UP) || (cls == CLS_STEEP_DOWN);
            up    = (cls == CLS_STEEP_UP) || (cls == CLS_FLAT_UP);
            // ties (p == 0) never step the minor axis
            take  = up ? (p_term > 0) : (p_term < 0);
            if (steep)
               py = py + 1'b1;
            else
               px = px + 1'b1;
            if (take) begin
               if (steep)
                  px = up ? px + 1'b1 : px - 1'b1;
               else
                  py = up ? py + 1'b1 : py - 1'b1;
               p_term = p_term + inc_diag;
            end else begin
               p_term = p_term + inc_straight;
            end
         end
         steep = (cls == CLS_STEEP_UP) || (cls == CLS_STEEP_DOWN);
         done  = steep ? (py >= major_stop) : (px >= major_stop);
         line_busy = !done;
         pix.valid = 1'b1;
         pix.x     = px;
         pix.y     = py;
         pix.color = color_q;
         pix.last  = done;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      pixel_type want;
      pixel_type pix;
      if (reset) begin
         line_busy    = 1'b0;
         px           = '0;
         py           = '0;
         major_stop   = '0;
         p_term       = '0;
         inc_straight = '0;
         inc_diag     = '0;
         cls          = CLS_STEEP_UP;
         color_q      = '0;
         expected_pixels.delete();
         fail_count    = 0;
         checked_count = 0;
         pending_count <= 0;
      end else begin
         // compare first: a result at this edge belongs to an earlier transaction
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("result transaction with no pending expectation");
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               checked_count++;
               check_field("pixel_valid", 32'(want.valid), 32'(rsp_pixel_valid));
               check_field("pixel_x", 32'(want.x), 32'(rsp_pixel_x));
               check_field("pixel_y", 32'(want.y), 32'(rsp_pixel_y));
               check_field("pixel_color", 32'(want.color), 32'(rsp_pixel_color));
               check_field("last_pixel", 32'(want.last), 32'(rsp_last_pixel));
            end
         end
         if (req_valid && !req_stall) begin
            rasterize_step(req_cmd, req_start_x, req_start_y, req_end_x, req_end_y,
                           req_line_color, pix);
            expected_pixels = {expected_pixels, pix};
         end
         pending_count <= expected_pixels.size();
      end
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Top of the line rasterizer testbench: clock, reset, line stimulus and receiver stalls.
// Depends on brl_pkg, bresenham_line_rasterizer_top and brl_checker.
module tb_top;
   import brl_pkg::*;

   localparam int COORD_BITS     = COORD_BITS_DEFAULT;
   localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
   localparam int ITEM_TARGET    = 2000;
   localparam int HOLD_START     = 1600;
   localparam int HOLD_CYCLES    = 150;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_cmd;
   logic [COORD_BITS-1:0]  req_start_x;
   logic [COORD_BITS-1:0]  req_start_y;
   logic [COORD_BITS-1:0]  req_end_x;
   logic [COORD_BITS-1:0]  req_end_y;
   logic [COLOR_BITS-1:0]  req_line_color;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_pixel_valid;
   logic [COORD_BITS-1:0]  rsp_pixel_x;
   logic [COORD_BITS-1:0]  rsp_pixel_y;
   logic [COLOR_BITS-1:0]  rsp_pixel_color;
   logic                   rsp_last_pixel;

   int fail_count;
   int pending_count;
   int checked_count;
   int sent_count;
   int start_count;
   int advance_count;
   int quiet_cycles;

   bresenham_line_rasterizer_top #(.COORD_BITS(COORD_BITS)) dut (.*);

   brl_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hold one transaction until accepted; idle at random outside the steady window
   task automatic send_txn(input logic cmd,
                           input int sx, input int sy,
                           input int ex, input int ey,
                           input logic [COLOR_BITS-1:0] color);
      while (!(sent_count >= 600 && sent_count < 1000) && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_start_x    <= COORD_BITS'(sx);
      req_start_y    <= COORD_BITS'(sy);
      req_end_x      <= COORD_BITS'(ex);
      req_end_y      <= COORD_BITS'(ey);
      req_line_color <= color;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      if (cmd == CMD_START)
         start_count++;
      else
         advance_count++;
   endtask

   // endpoint fields are don't-care on advance, so fill them with noise
   task automatic send_advance();
      send_txn(CMD_ADVANCE, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   function automatic int clamp_coord(input int v);
      return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   function automatic int pick_coord();
      int r;
      r = $urandom_range(0, 9);
      return (r == 0) ? 0 : (r == 1) ? COORD_MAX : $urandom_range(0, COORD_MAX);
   endfunction

   task automatic random_line();
      int span, sx, sy, ex, ey, off, adx, ady, major, n, r;
      span = ($urandom_range(0, 99) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
      sx   = pick_coord();
      sy   = pick_coord();
      off  = $urandom_range(0, 2 * span);
      ex   = clamp_coord(sx + off - span);
      off  = $urandom_range(0, 2 * span);
      ey   = clamp_coord(sy + off - span);
      adx  = (ex > sx) ? ex - sx : sx - ex;
      ady  = (ey > sy) ? ey - sy : sy - ey;
      major = (adx > ady) ? adx : ady;
      r = $urandom_range(0, 99);
      // mostly full lines; some overrun into idle, some cut short by a restart
      if (r < 75)
         n = major;
      else if (r < 87)
         n = major + $urandom_range(1, 3);
      else
         n = (major == 0) ? 0 : $urandom_range(0, major - 1);
      send_txn(CMD_START, sx, sy, ex, ey, $urandom);
      repeat (n) send_advance();
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_START;
      req_start_x    = '0;
      req_start_y    = '0;
      req_end_x      = '0;
      req_end_y      = '0;
      req_line_color = '0;
      sent_count     = 0;
      start_count    = 0;
      advance_count  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle advance, single point, extreme diagonals, all four classes,
      // a tie on the decision term, restarts mid-line and an overrun
      send_advance();
      send_txn(CMD_START, 0, 0, 0, 0, 32'h0000_0000);
      send_advance();
      send_txn(CMD_START, COORD_MAX, COORD_MAX, 0, 0, 32'hFFFF_FFFF);
      repeat (2) send_advance();
      send_txn(CMD_START, 0, COORD_MAX, COORD_MAX, 0, 32'hA5A5_5A5A);
      repeat (2) send_advance();
      send_txn(CMD_START, 0, 0, COORD_MAX, 1, 32'h5A5A_A5A5);
      send_advance();
      send_txn(CMD_START, COORD_MAX, 0, 0, 1, 32'h0F0F_F0F0);
      send_advance();
      send_txn(CMD_START, 10, 10, 12, 11, 32'h1234_5678);
      repeat (3) send_advance();
      send_txn(CMD_START, 5, 8, 5, 5, 32'h8765_4321);
      repeat (3) send_advance();
      send_txn(CMD_START, 20, 20, 17, 21, 32'hDEAD_BEEF);
      repeat (3) send_advance();

      while (sent_count < ITEM_TARGET) begin
         if ($urandom_range(0, 19) == 0)
            send_advance();
         random_line();
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);

      $display("Sent %0d line starts and %0d advances; %0d pixel results checked.",
               start_count, advance_count, checked_count);
      $display("Run included idle advances, mid-line restarts, edge coordinates %s%0d%s",
               "and a ", HOLD_CYCLES, "-cycle hold-off.");
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver: random stalls, a steady window and one long hold-off
   initial begin : receiver
      int cyc;
      cyc = 0;
      rsp_stall = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (cyc == HOLD_START) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            cyc += HOLD_CYCLES;
         end else begin
            rsp_stall <= (cyc >= 400 && cyc < 1000) ? 1'b0 : ($urandom_range(0, 99) < 12);
            @(posedge clock);
            cyc++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
